// File: hdl/soc_pkg.sv
`default_nettype none

package soc_pkg;

   localparam int ROW_MAX        = 32;
   localparam int INDEX_BITS     = 20;
   localparam int VALUE_BITS     = 32;
   localparam int VAR_BITS       = 8;
   localparam int THETA_BITS     = 17;
   localparam int FRAC_BITS      = 16;
   localparam int ADDR_BITS      = $clog2(ROW_MAX);
   localparam int CNT_BITS       = $clog2(ROW_MAX + 1);
   localparam int SCALE_BITS     = VALUE_BITS + 1;
   localparam int PROD_BITS      = SCALE_BITS + THETA_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_METHOD        = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_VARIABLES = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THETA         = 2'd2;

   localparam logic                  METHOD_RESET = 1'b1;
   localparam logic [THETA_BITS-1:0] THETA_RESET  = 17'd16384;

   typedef struct packed {
      logic                  method;
      logic                  use_variables;
      logic [THETA_BITS-1:0] theta;
   } soc_cfg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] column;
      logic [VALUE_BITS-1:0] value;
      logic                  match;
   } soc_entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      soc_entry_type        wr_data;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } soc_mem_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_MULT,
      ST_KEEP_RD,
      ST_KEEP_EV,
      ST_FLUSH
   } soc_state_type;

endpackage

`default_nettype wire

// File: hdl/soc_row_buf.sv
`default_nettype none

module soc_row_buf (
   input  wire logic                     clock,
   input  wire soc_pkg::soc_mem_req_type mem_req,
   output soc_pkg::soc_entry_type        rd_data
);

   soc_pkg::soc_entry_type mem [soc_pkg::ROW_MAX];
   soc_pkg::soc_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/soc_engine.sv
`default_nettype none

module soc_engine (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire soc_pkg::soc_cfg_type                  cfg,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [soc_pkg::INDEX_BITS-1:0]        req_row_index,
   input  wire logic [soc_pkg::INDEX_BITS-1:0]        req_column,
   input  wire logic signed [soc_pkg::VALUE_BITS-1:0] req_value,
   input  wire logic [soc_pkg::VAR_BITS-1:0]          req_row_variable,
   input  wire logic [soc_pkg::VAR_BITS-1:0]          req_column_variable,
   input  wire logic                                  req_last_in_row,
   input  wire logic                                  req_empty_row,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [soc_pkg::INDEX_BITS-1:0]             rsp_out_column,
   output logic signed [soc_pkg::VALUE_BITS-1:0]      rsp_out_value,
   output logic                                       rsp_entry_valid,
   output logic                                       rsp_last_of_row,
   output logic                                       rsp_row_overflow,
   output soc_pkg::soc_mem_req_type                   mem_req,
   input  wire soc_pkg::soc_entry_type                rd_data
);

   localparam int CB = soc_pkg::CNT_BITS;
   localparam int AB = soc_pkg::ADDR_BITS;
   localparam int IB = soc_pkg::INDEX_BITS;
   localparam int VB = soc_pkg::VALUE_BITS;
   localparam int SB = soc_pkg::SCALE_BITS;
   localparam int PB = soc_pkg::PROD_BITS;
   localparam int FB = soc_pkg::FRAC_BITS;

   soc_pkg::soc_state_type state_ff, state_in;
   logic [CB-1:0]          cnt_ff, cnt_in;
   logic [CB-1:0]          addr_ff, addr_in;
   logic                   diag_ff, diag_in;
   logic [VB-1:0]          dval_ff, dval_in;
   logic [IB-1:0]          col0_ff, col0_in;
   logic                   ovf_ff, ovf_in;
   logic                   inflight_ff, inflight_in;
   logic                   have_ff, have_in;
   logic signed [SB-1:0]   scale_ff, scale_in;
   logic signed [PB-1:0]   prod_ff, prod_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [IB-1:0]          pend_col_ff, pend_col_in;
   logic [VB-1:0]          pend_val_ff, pend_val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IB-1:0]          rsp_col_ff, rsp_col_in;
   logic [VB-1:0]          rsp_val_ff, rsp_val_in;
   logic                   rsp_entry_ff, rsp_entry_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                          out_free;
   logic                          accept;
   logic [CB-1:0]                 first;
   logic signed [SB-1:0]          v33;
   logic signed [SB-1:0]          cand;
   logic signed [PB-1:0]          lhs;
   logic signed [soc_pkg::THETA_BITS:0] theta_s;
   logic                          qual;
   logic                          neg;
   logic                          better;
   logic                          keep;
   logic                          is_diag;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (state_ff != soc_pkg::ST_IDLE) || !out_free;
      accept    = req_valid && !req_stall;
      first     = cfg.method ? CB'(1) : {{(CB-1){1'b0}}, diag_ff};
      is_diag   = (req_column == req_row_index);
      v33       = {rd_data.value[VB-1], rd_data.value};
      cand      = cfg.method ? -v33 : v33;
      lhs       = {{(PB-SB-FB){cand[SB-1]}}, cand, {FB{1'b0}}};
      theta_s   = {1'b0, cfg.theta};
      qual      = cfg.method || !cfg.use_variables || rd_data.match;
      neg       = diag_ff && dval_ff[VB-1];
      better    = (cfg.method || neg) ? (cand > scale_ff) : (cand < scale_ff);
      if (cfg.method) begin
         keep = lhs >= prod_ff;
      end else if (neg) begin
         keep = qual && (lhs > prod_ff);
      end else begin
         keep = qual && (lhs < prod_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      diag_in       = diag_ff;
      dval_in       = dval_ff;
      col0_in       = col0_ff;
      ovf_in        = ovf_ff;
      inflight_in   = inflight_ff;
      have_in       = have_ff;
      scale_in      = scale_ff;
      prod_in       = prod_ff;
      pend_valid_in = pend_valid_ff;
      pend_col_in   = pend_col_ff;
      pend_val_in   = pend_val_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_col_in    = rsp_col_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      mem_req                 = '0;
      mem_req.wr_addr         = cnt_ff[AB-1:0];
      mem_req.wr_data.column  = req_column;
      mem_req.wr_data.value   = req_value;
      mem_req.wr_data.match   = (req_row_variable == req_column_variable);
      mem_req.rd_addr         = addr_ff[AB-1:0];

      unique case (state_ff)
         soc_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_empty_row) begin
                  if (cnt_ff != '0) begin
                     state_in = soc_pkg::ST_START;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_col_in   = '0;
                     rsp_val_in   = '0;
                     rsp_entry_in = 1'b0;
                     rsp_last_in  = 1'b1;
                     rsp_ovf_in   = 1'b0;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     diag_in = is_diag;
                     dval_in = is_diag ? req_value : '0;
                     col0_in = req_column;
                  end
                  if (cnt_ff < CB'(soc_pkg::ROW_MAX)) begin
                     mem_req.wr_en = 1'b1;
                     cnt_in        = cnt_ff + CB'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_last_in_row) begin
                     state_in = soc_pkg::ST_START;
                  end
               end
            end
         end
         soc_pkg::ST_START: begin
            addr_in       = first;
            inflight_in   = 1'b0;
            have_in       = 1'b0;
            pend_valid_in = cfg.method || diag_ff;
            pend_col_in   = col0_ff;
            pend_val_in   = diag_ff ? dval_ff : '0;
            state_in      = soc_pkg::ST_SCAN;
         end
         soc_pkg::ST_SCAN: begin
            if (addr_ff < cnt_ff) begin
               mem_req.rd_en = 1'b1;
               addr_in       = addr_ff + CB'(1);
               inflight_in   = 1'b1;
            end else begin
               inflight_in = 1'b0;
               if (!inflight_ff) begin
                  state_in = soc_pkg::ST_MULT;
               end
            end
            if (inflight_ff && qual && (!have_ff || better)) begin
               scale_in = cand;
               have_in  = 1'b1;
            end
         end
         soc_pkg::ST_MULT: begin
            prod_in  = scale_ff * theta_s;
            addr_in  = first;
            state_in = have_ff ? soc_pkg::ST_KEEP_RD : soc_pkg::ST_FLUSH;
         end
         soc_pkg::ST_KEEP_RD: begin
            if (addr_ff < cnt_ff) begin
               mem_req.rd_en = 1'b1;
               addr_in       = addr_ff + CB'(1);
               state_in      = soc_pkg::ST_KEEP_EV;
            end else begin
               state_in = soc_pkg::ST_FLUSH;
            end
         end
         soc_pkg::ST_KEEP_EV: begin
            if (!keep) begin
               state_in = soc_pkg::ST_KEEP_RD;
            end else if (!pend_valid_ff) begin
               pend_valid_in = 1'b1;
               pend_col_in   = rd_data.column;
               pend_val_in   = rd_data.value;
               state_in      = soc_pkg::ST_KEEP_RD;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = pend_col_ff;
               rsp_val_in   = pend_val_ff;
               rsp_entry_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_ovf_in   = ovf_ff;
               pend_col_in  = rd_data.column;
               pend_val_in  = rd_data.value;
               state_in     = soc_pkg::ST_KEEP_RD;
            end
         end
         soc_pkg::ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_col_in    = pend_valid_ff ? pend_col_ff : '0;
               rsp_val_in    = pend_valid_ff ? pend_val_ff : '0;
               rsp_entry_in  = pend_valid_ff;
               rsp_last_in   = 1'b1;
               rsp_ovf_in    = ovf_ff;
               pend_valid_in = 1'b0;
               cnt_in        = '0;
               ovf_in        = 1'b0;
               diag_in       = 1'b0;
               dval_in       = '0;
               state_in      = soc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = soc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= soc_pkg::ST_IDLE;
         cnt_ff        <= '0;
         diag_ff       <= 1'b0;
         dval_ff       <= '0;
         ovf_ff        <= 1'b0;
         inflight_ff   <= 1'b0;
         have_ff       <= 1'b0;
         scale_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         diag_ff       <= diag_in;
         dval_ff       <= dval_in;
         ovf_ff        <= ovf_in;
         inflight_ff   <= inflight_in;
         have_ff       <= have_in;
         scale_ff      <= scale_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      col0_ff     <= col0_in;
      prod_ff     <= prod_in;
      pend_col_ff <= pend_col_in;
      pend_val_ff <= pend_val_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_column   = rsp_col_ff;
   assign rsp_out_value    = rsp_val_ff;
   assign rsp_entry_valid  = rsp_entry_ff;
   assign rsp_last_of_row  = rsp_last_ff;
   assign rsp_row_overflow = rsp_ovf_ff;

   // fill count never passes the buffer depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(soc_pkg::ROW_MAX))
      else $error("row fill count above buffer depth");

   // dropped entries only once the buffer is full
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (cnt_ff == CB'(soc_pkg::ROW_MAX)))
      else $error("overflow flagged with room left in buffer");

   // no held word survives into the fill phase
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == soc_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("pending word left over after row close");

   // keep pass only runs with a row scale
   a_keep_scale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == soc_pkg::ST_KEEP_EV) |-> have_ff)
      else $error("keep test without row scale");

   // row close always ends in a last word
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == soc_pkg::ST_FLUSH) && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("row close did not produce a last word");

endmodule

`default_nettype wire

// File: hdl/amg_strength_of_connection_top.sv
// Strength-of-connection filter: takes one sparse row at a time, one nonzero per input
// word, diagonal first, the row closed by last_in_row or by an empty_row word. Entries
// are written into a 32-deep row buffer at one word per cycle while req_stall is low.
// After the row closes, input is stalled while the row is processed: a start step, a
// scan pass over the buffered entries that finds the row scale, a multiply step for
// scale times theta, then a keep pass that reads each entry from the buffer and then
// tests it, and a final step that closes the row; the keep pass and the final step wait
// while the result side stalls. Kept words leave through a one-word output register,
// the last word of each row carries last_of_row, and rows longer than 32 entries drop
// the extra entries and flag row_overflow on every word of that row. Configuration
// writes are taken on any cycle and must only be issued while the block is idle.

`default_nettype none

module amg_strength_of_connection_top (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [soc_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  wire logic [soc_pkg::THETA_BITS-1:0]            csr_data,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic [soc_pkg::INDEX_BITS-1:0]            req_row_index,
   input  wire logic [soc_pkg::INDEX_BITS-1:0]            req_column,
   input  wire logic signed [soc_pkg::VALUE_BITS-1:0]     req_value,
   input  wire logic [soc_pkg::VAR_BITS-1:0]              req_row_variable,
   input  wire logic [soc_pkg::VAR_BITS-1:0]              req_column_variable,
   input  wire logic                                      req_last_in_row,
   input  wire logic                                      req_empty_row,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [soc_pkg::INDEX_BITS-1:0]                 rsp_out_column,
   output logic signed [soc_pkg::VALUE_BITS-1:0]          rsp_out_value,
   output logic                                           rsp_entry_valid,
   output logic                                           rsp_last_of_row,
   output logic                                           rsp_row_overflow
);

   soc_pkg::soc_cfg_type     cfg_ff, cfg_in;
   soc_pkg::soc_mem_req_type mem_req;
   soc_pkg::soc_entry_type   rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            soc_pkg::CSR_METHOD:        cfg_in.method        = csr_data[0];
            soc_pkg::CSR_USE_VARIABLES: cfg_in.use_variables = csr_data[0];
            soc_pkg::CSR_THETA:         cfg_in.theta         = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method        <= soc_pkg::METHOD_RESET;
         cfg_ff.use_variables <= 1'b0;
         cfg_ff.theta         <= soc_pkg::THETA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   soc_row_buf u_row_buf (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   soc_engine u_engine (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_row_index       (req_row_index),
      .req_column          (req_column),
      .req_value           (req_value),
      .req_row_variable    (req_row_variable),
      .req_column_variable (req_column_variable),
      .req_last_in_row     (req_last_in_row),
      .req_empty_row       (req_empty_row),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_column      (rsp_out_column),
      .rsp_out_value       (rsp_out_value),
      .rsp_entry_valid     (rsp_entry_valid),
      .rsp_last_of_row     (rsp_last_of_row),
      .rsp_row_overflow    (rsp_row_overflow),
      .mem_req             (mem_req),
      .rd_data             (rd_data)
   );

endmodule

`default_nettype wire

// File: bench/amg_strength_of_connection_top_tb.sv
`timescale 1ns / 100ps

module amg_strength_of_connection_top_tb;

   localparam int IB           = soc_pkg::INDEX_BITS;
   localparam int VB           = soc_pkg::VALUE_BITS;
   localparam int RB           = soc_pkg::VAR_BITS;
   localparam int TB           = soc_pkg::THETA_BITS;
   localparam int XB           = soc_pkg::CSR_INDEX_BITS;
   localparam int PHASE_ITEMS  = 47;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [IB-1:0] row_index;
      logic [IB-1:0] column;
      logic [VB-1:0] value;
      logic [RB-1:0] row_var;
      logic [RB-1:0] col_var;
      logic          last;
      logic          empty;
   } entry_word_type;

   typedef struct packed {
      logic [IB-1:0] column;
      logic [VB-1:0] value;
      logic          entry_valid;
      logic          last;
      logic          overflow;
   } rsp_word_type;

   class strength_checker_type;
      logic [IB-1:0]  buf_col [soc_pkg::ROW_MAX];
      logic [VB-1:0]  buf_val [soc_pkg::ROW_MAX];
      logic           buf_match [soc_pkg::ROW_MAX];
      int             fill = 0;
      logic [VB-1:0]  diag_word = '0;
      logic           diag_seen = 1'b0;
      logic           overflowed = 1'b0;
      logic           cfg_modified = soc_pkg::METHOD_RESET;
      logic           cfg_match_vars = 1'b0;
      logic [TB-1:0]  cfg_theta = soc_pkg::THETA_RESET;
      rsp_word_type   kept_q[$];
      int             mismatches = 0;

      function void set_reg(logic [XB-1:0] idx, logic [TB-1:0] data);
         case (idx)
            soc_pkg::CSR_METHOD:        cfg_modified = data[0];
            soc_pkg::CSR_USE_VARIABLES: cfg_match_vars = data[0];
            soc_pkg::CSR_THETA:         cfg_theta = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return kept_q.size();
      endfunction

      function rsp_word_type kept(logic [IB-1:0] c, logic [VB-1:0] v);
         kept = '{column: c, value: v, entry_valid: 1'b1, last: 1'b0, overflow: 1'b0};
      endfunction

      function void emit(rsp_word_type outs[$]);
         if (outs.size() == 0) outs.push_back('0);
         foreach (outs[j]) begin
            outs[j].overflow = overflowed;
            outs[j].last = (j == outs.size() - 1);
            kept_q.push_back(outs[j]);
         end
      endfunction

      function void close_row();
         rsp_word_type outs[$];
         longint       dval, scale, v, th;
         bit           have, neg;
         int           first;
         dval = longint'($signed(diag_word));
         th = longint'(cfg_theta);
         have = 1'b0;
         scale = 0;
         if (cfg_modified) begin
            outs.push_back(kept(buf_col[0], diag_seen ? diag_word : '0));
            for (int j = 1; j < fill; j++) begin
               v = -longint'($signed(buf_val[j]));
               if (!have || v > scale) begin
                  scale = v;
                  have = 1'b1;
               end
            end
            for (int j = 1; have && j < fill; j++) begin
               v = longint'($signed(buf_val[j]));
               if ((-v) * 65536 >= scale * th) outs.push_back(kept(buf_col[j], buf_val[j]));
            end
         end else begin
            neg = diag_seen && dval < 0;
            first = 0;
            if (diag_seen) begin
               outs.push_back(kept(buf_col[0], diag_word));
               first = 1;
            end
            for (int j = first; j < fill; j++) begin
               v = longint'($signed(buf_val[j]));
               if (!cfg_match_vars || buf_match[j]) begin
                  if (!have || (neg ? v > scale : v < scale)) begin
                     scale = v;
                     have = 1'b1;
                  end
               end
            end
            for (int j = first; have && j < fill; j++) begin
               v = longint'($signed(buf_val[j]));
               if (!cfg_match_vars || buf_match[j]) begin
                  if (neg ? (v * 65536 > scale * th) : (v * 65536 < scale * th))
                     outs.push_back(kept(buf_col[j], buf_val[j]));
               end
            end
         end
         emit(outs);
         fill = 0;
         overflowed = 1'b0;
         diag_seen = 1'b0;
         diag_word = '0;
      endfunction

      function void note_word(entry_word_type w);
         rsp_word_type none[$];
         if (w.empty) begin
            if (fill > 0) close_row();
            else emit(none);
            return;
         end
         if (fill == 0) begin
            diag_seen = (w.column == w.row_index);
            diag_word = diag_seen ? w.value : '0;
         end
         if (fill < soc_pkg::ROW_MAX) begin
            buf_col[fill] = w.column;
            buf_val[fill] = w.value;
            buf_match[fill] = (w.row_var == w.col_var);
            fill++;
         end else begin
            overflowed = 1'b1;
         end
         if (w.last) close_row();
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type exp;
         if (kept_q.size() == 0) begin
            $display("%0t: unexpected word col %h val %h ev %b last %b ovf %b", $time,
                     got.column, got.value, got.entry_valid, got.last, got.overflow);
            mismatches++;
            return;
         end
         exp = kept_q.pop_front();
         if (got !== exp) begin
            $display("%0t: expected col %h val %h ev %b last %b ovf %b", $time,
                     exp.column, exp.value, exp.entry_valid, exp.last, exp.overflow);
            $display("%0t:   actual col %h val %h ev %b last %b ovf %b", $time,
                     got.column, got.value, got.entry_valid, got.last, got.overflow);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [XB-1:0]        csr_index = '0;
   logic [TB-1:0]        csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [IB-1:0]        req_row_index = '0;
   logic [IB-1:0]        req_column = '0;
   logic signed [VB-1:0] req_value = '0;
   logic [RB-1:0]        req_row_variable = '0;
   logic [RB-1:0]        req_column_variable = '0;
   logic                 req_last_in_row = 1'b0;
   logic                 req_empty_row = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [IB-1:0]        rsp_out_column;
   logic signed [VB-1:0] rsp_out_value;
   logic                 rsp_entry_valid;
   logic                 rsp_last_of_row;
   logic                 rsp_row_overflow;

   strength_checker_type sb = new;
   int                   sent_items = 0;
   int                   cycle_count = 0;
   bit                   burst = 1'b0;
   bit                   hold_off_req = 1'b0;

   amg_strength_of_connection_top uut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word('{column: rsp_out_column, value: rsp_out_value,
                         entry_valid: rsp_entry_valid, last: rsp_last_of_row,
                         overflow: rsp_row_overflow});
   end

   // result side: random stalls, one long hold-off when asked
   initial begin
      int wait_cycles;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            wait_cycles = HOLD_CYCLES;
         end else if (burst) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 7);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_word(input logic [IB-1:0] row, input logic [IB-1:0] col,
                            input logic [VB-1:0] val, input logic [RB-1:0] rv,
                            input logic [RB-1:0] cv, input logic last,
                            input logic empty);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_row_index <= row;
      req_column <= col;
      req_value <= val;
      req_row_variable <= rv;
      req_column_variable <= cv;
      req_last_in_row <= last;
      req_empty_row <= empty;
      do @(posedge clock); while (req_stall);
      sb.note_word('{row_index: row, column: col, value: val, row_var: rv, col_var: cv,
                     last: last, empty: empty});
      sent_items++;
   endtask

   task automatic configure(input logic m, input logic u, input logic [TB-1:0] t);
      logic [XB-1:0] idx [3];
      logic [TB-1:0] data [3];
      idx[0] = soc_pkg::CSR_METHOD;
      idx[1] = soc_pkg::CSR_USE_VARIABLES;
      idx[2] = soc_pkg::CSR_THETA;
      data[0] = TB'(m);
      data[1] = TB'(u);
      data[2] = t;
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= data[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(idx[i], data[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [IB-1:0] rand_index();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return IB'($urandom);
      endcase
   endfunction

   function automatic logic [VB-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         3: return 32'(($urandom_range(0, 64) - 32) * 32'h4000);
         default: return 32'($urandom_range(0, 32'h8_0000) - 32'h4_0000);
      endcase
   endfunction

   task automatic send_random_row();
      int            n, pick;
      logic [IB-1:0] row, col;
      logic [RB-1:0] rv, cv;
      logic          has_diag, by_empty;
      pick = $urandom_range(0, 99);
      row = rand_index();
      rv = RB'($urandom);
      if (pick < 8) begin
         send_word(rand_index(), rand_index(), $urandom, RB'($urandom),
                   RB'($urandom), 1'($urandom), 1'b1);
         return;
      end
      n = (pick < 12) ? $urandom_range(32, 37) : $urandom_range(1, 8);
      has_diag = ($urandom_range(0, 3) != 0);
      by_empty = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < n; k++) begin
         if (k == 0 && has_diag) begin
            col = row;
         end else begin
            col = rand_index();
            if (k == 0 && col == row) col = ~row;
         end
         cv = $urandom_range(0, 1) ? rv : RB'($urandom);
         send_word(row, col, rand_value(), rv, cv, (k == n - 1) && !by_empty, 1'b0);
      end
      if (by_empty)
         send_word(rand_index(), rand_index(), $urandom, RB'($urandom),
                   RB'($urandom), 1'($urandom), 1'b1);
   endtask

   initial begin
      logic          m_tab [6];
      logic          u_tab [6];
      logic [TB-1:0] t_tab [6];
      m_tab = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
      u_tab = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
      t_tab = '{17'd16384, 17'd32768, 17'd0, 17'd65536, 17'd65536, 17'd1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // modified mode at reset settings
      send_word(20'h5A5A5, 20'hA5A5A, 32'hDEAD_BEEF, 8'hFF, 8'h00, 1'b1, 1'b1);
      send_word(20'd5, 20'd5, -32'sh2_0000, 8'd1, 8'd1, 1'b1, 1'b0);
      send_word(20'd7, 20'd3, 32'h1_0000, 8'd1, 8'd1, 1'b0, 1'b0);
      send_word(20'd7, 20'd9, -32'sh3_0000, 8'd1, 8'd2, 1'b1, 1'b0);
      send_word(20'hFFFFF, 20'hFFFFF, 32'h8000_0000, 8'hFF, 8'hFF, 1'b0, 1'b0);
      send_word(20'hFFFFF, 20'd0, 32'h8000_0000, 8'hFF, 8'h00, 1'b0, 1'b0);
      send_word(20'hFFFFF, 20'd1, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
      send_word(20'd2, 20'd2, 32'h4_0000, 8'd0, 8'd0, 1'b0, 1'b0);
      send_word(20'd2, 20'd4, -32'sh1_0000, 8'd0, 8'd0, 1'b0, 1'b0);
      send_word(20'h12345, 20'h54321, 32'h1234_5678, 8'h3C, 8'hC3, 1'b0, 1'b1);
      while (sent_items < PHASE_ITEMS) send_random_row();

      for (int p = 0; p < 6; p++) begin
         settle();
         configure(m_tab[p], u_tab[p], t_tab[p]);
         if (p == 0) begin
            // classical: negative diagonal, positive diagonal, no diagonal
            send_word(20'd10, 20'd10, -32'sh4_0000, 8'd0, 8'd0, 1'b0, 1'b0);
            send_word(20'd10, 20'd11, 32'h1_0000, 8'd0, 8'd0, 1'b0, 1'b0);
            send_word(20'd10, 20'd12, -32'sh8000, 8'd0, 8'd0, 1'b1, 1'b0);
            send_word(20'd20, 20'd20, 32'h4_0000, 8'd0, 8'd0, 1'b0, 1'b0);
            send_word(20'd20, 20'd21, -32'sh2_0000, 8'd0, 8'd0, 1'b0, 1'b0);
            send_word(20'd20, 20'd22, -32'sh4000, 8'd0, 8'd0, 1'b1, 1'b0);
            send_word(20'd30, 20'd31, -32'sh1_0000, 8'd0, 8'd0, 1'b0, 1'b0);
            send_word(20'd30, 20'd32, 32'h1_0000, 8'd0, 8'd0, 1'b1, 1'b0);
         end
         if (p == 1) begin
            // variable matching: nothing qualifies, then nothing kept at all
            send_word(20'd40, 20'd40, 32'hFFFF_FFFF, 8'd3, 8'd3, 1'b0, 1'b0);
            send_word(20'd40, 20'd41, 32'h1_0000, 8'd3, 8'd4, 1'b1, 1'b0);
            send_word(20'd50, 20'd51, -32'sh1_0000, 8'd1, 8'd2, 1'b1, 1'b0);
            hold_off_req = 1'b1;
         end
         burst = (p == 3);
         while (sent_items < PHASE_ITEMS * (p + 2)) send_random_row();
         burst = 1'b0;
      end

      settle();
      if (sb.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
